### rtl/core/olmsr_pkg.sv
// ----------------------------------------------------------------------------
// olmsr_pkg
// Shared types and constants for the ordered box list engine: operation
// codes, sequencer states and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package olmsr_pkg;

  // Fixed port field widths
  localparam int OP_W  = 3;
  localparam int BOX_W = 11;
  localparam int SUM_W = 20;

  // Default list capacity and link index width
  localparam int MAX_BOXES_DEF = 1024;
  localparam int IDX_W_DEF     = $clog2(MAX_BOXES_DEF + 1);

  // Box count after reset, before clamping to the capacity
  localparam int COUNT_RESET = 1024;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INIT       = 3'd0,
    OP_MOVE_LEFT  = 3'd1,
    OP_MOVE_RIGHT = 3'd2,
    OP_SWAP       = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_REPORT     = 3'd5
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RD_Y,
    S_DECIDE,
    S_JOIN,
    S_WALK,
    S_FIX,
    S_OUT
  } state_t;

endpackage

### rtl/core/ordered_list_move_swap_reverse.sv
// ----------------------------------------------------------------------------
// ordered_list_move_swap_reverse
// Boxes 1..n kept as a circular doubly linked list in two link tables with a
// lazy reversal flag; supports init, moves, swap, reverse and odd sum report.
// ----------------------------------------------------------------------------
// Each item is taken only while the engine is idle, so items are handled one
// at a time. Reverse and ignored items are handled in the idle state. A move
// or swap steps through read x, read y, decide, then three or four joins, one
// join per cycle, since each link table has a single write port. Init writes
// the head entry, then one table row per box. A report walks the list, one
// next link per cycle through the registered read of the next table. A
// finished sum sits in the output register while the next item is taken. The
// link tables need an init item before any move, swap or report.
module ordered_list_move_swap_reverse #(
  parameter int MAX_BOXES = olmsr_pkg::MAX_BOXES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [olmsr_pkg::BOX_W-1:0]  cfg_num_boxes,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [olmsr_pkg::OP_W-1:0]   in_operation,
  input  logic [olmsr_pkg::BOX_W-1:0]  in_box_x,
  input  logic [olmsr_pkg::BOX_W-1:0]  in_box_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [olmsr_pkg::SUM_W-1:0]  out_odd_position_sum
);

  localparam int IDX_W  = $clog2(MAX_BOXES + 1);
  localparam int PROD_W = 2 * IDX_W + 1;
  localparam int SUM_W  = olmsr_pkg::SUM_W;
  localparam int COUNT_RST = (olmsr_pkg::COUNT_RESET > MAX_BOXES) ? MAX_BOXES
                                                                   : olmsr_pkg::COUNT_RESET;

  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  tri_r, tri_nxt;
  logic [31:0]       cfg_wide;
  logic [PROD_W-1:0] prod;

  // Clamp the written count to 1..MAX_BOXES
  always_comb begin
    cfg_wide  = 32'(cfg_num_boxes);
    count_nxt = count_r;
    if (cfg_we) begin
      if (cfg_wide == 32'd0) begin
        count_nxt = IDX_W'(1);
      end else if (cfg_wide > 32'(MAX_BOXES)) begin
        count_nxt = IDX_W'(MAX_BOXES);
      end else begin
        count_nxt = IDX_W'(cfg_wide);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= IDX_W'(COUNT_RST);
    end else begin
      count_r <= count_nxt;
    end
  end

  // Triangular number n(n+1)/2 for the reversal correction
  assign prod    = PROD_W'(count_r) * (PROD_W'(count_r) + PROD_W'(1));
  assign tri_nxt = SUM_W'(prod >> 1);

  always_ff @(posedge clk) begin
    tri_r <= tri_nxt;
  end

  olmsr_engine #(
    .MAX_BOXES(MAX_BOXES),
    .IDX_W    (IDX_W)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_box_x            (in_box_x),
    .in_box_y            (in_box_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_odd_position_sum(out_odd_position_sum),
    .count               (count_r),
    .tri_sum             (tri_r)
  );

endmodule

### rtl/core/olmsr_link_mem.sv
// ----------------------------------------------------------------------------
// olmsr_link_mem
// One link table: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module olmsr_link_mem #(
  parameter int DEPTH  = olmsr_pkg::MAX_BOXES_DEF + 1,
  parameter int ADDR_W = olmsr_pkg::IDX_W_DEF,
  parameter int DATA_W = olmsr_pkg::IDX_W_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/olmsr_engine.sv
// ----------------------------------------------------------------------------
// olmsr_engine
// Sequencer and datapath around the next and previous link tables: list
// init sweep, read-decide-rewrite for moves and swaps, pointer walk for the
// odd position sum, and the result register.
// ----------------------------------------------------------------------------
module olmsr_engine #(
  parameter int MAX_BOXES = olmsr_pkg::MAX_BOXES_DEF,
  parameter int IDX_W     = $clog2(MAX_BOXES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [olmsr_pkg::OP_W-1:0]   in_operation,
  input  logic [olmsr_pkg::BOX_W-1:0]  in_box_x,
  input  logic [olmsr_pkg::BOX_W-1:0]  in_box_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [olmsr_pkg::SUM_W-1:0]  out_odd_position_sum,
  input  logic [IDX_W-1:0]             count,
  input  logic [olmsr_pkg::SUM_W-1:0]  tri_sum
);

  localparam int STEP_W = $clog2(MAX_BOXES + 2);
  localparam int SUM_W  = olmsr_pkg::SUM_W;

  // Map an index that falls outside the table to the head entry
  function automatic logic [IDX_W-1:0] fix_idx(input logic [IDX_W-1:0] v);
    return (32'(v) <= 32'(MAX_BOXES)) ? v : '0;
  endfunction

  olmsr_pkg::state_t state_r, state_nxt;

  logic [olmsr_pkg::OP_W-1:0] op_r, op_nxt;
  logic [IDX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [IDX_W-1:0]  nx_r, nx_nxt, px_r, px_nxt;
  logic [IDX_W-1:0]  ja_r [4];
  logic [IDX_W-1:0]  ja_nxt [4];
  logic [IDX_W-1:0]  jb_r [4];
  logic [IDX_W-1:0]  jb_nxt [4];
  logic [1:0]        jleft_r, jleft_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              odd_r, odd_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              rev_r, rev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;

  // Link table ports
  logic             n_we, p_we;
  logic [IDX_W-1:0] n_waddr, n_wdata, p_waddr, p_wdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] n_rd, p_rd, n_fx, p_fx;

  // Decision results for a move or swap
  logic                       dec_sw, dec_skip;
  logic [olmsr_pkg::OP_W-1:0] dec_op;
  logic [IDX_W-1:0]           dx, dy, nxv, pxv, nyv, pyv;
  logic [IDX_W-1:0]           dec_a [4];
  logic [IDX_W-1:0]           dec_b [4];
  logic [1:0]                 dec_left;

  logic             args_ok;
  logic [IDX_W-1:0] x_in, y_in;

  olmsr_link_mem #(
    .DEPTH (MAX_BOXES + 1),
    .ADDR_W(IDX_W),
    .DATA_W(IDX_W)
  ) u_next_mem (
    .clk  (clk),
    .we   (n_we),
    .waddr(n_waddr),
    .wdata(n_wdata),
    .raddr(raddr),
    .rdata(n_rd)
  );

  olmsr_link_mem #(
    .DEPTH (MAX_BOXES + 1),
    .ADDR_W(IDX_W),
    .DATA_W(IDX_W)
  ) u_prev_mem (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(raddr),
    .rdata(p_rd)
  );

  assign n_fx = fix_idx(n_rd);
  assign p_fx = fix_idx(p_rd);

  assign x_in = IDX_W'(in_box_x);
  assign y_in = IDX_W'(in_box_y);

  // Check labels of a move or swap against the current box count
  assign args_ok = (in_box_x != in_box_y) && (in_box_x != '0) && (in_box_y != '0) &&
                   (32'(in_box_x) <= 32'(count)) && (32'(in_box_y) <= 32'(count));

  // Work out the link rewrites once the links of both boxes are in hand;
  // the y links come straight from the table outputs
  always_comb begin
    dec_sw = (op_r == olmsr_pkg::OP_SWAP) && (n_fx == x_r);
    dx  = dec_sw ? y_r  : x_r;
    dy  = dec_sw ? x_r  : y_r;
    nxv = dec_sw ? n_fx : nx_r;
    pxv = dec_sw ? p_fx : px_r;
    nyv = dec_sw ? nx_r : n_fx;
    pyv = dec_sw ? px_r : p_fx;

    // Reversal trades left and right moves
    dec_op = op_r;
    if (op_r != olmsr_pkg::OP_SWAP && rev_r) begin
      dec_op = (op_r == olmsr_pkg::OP_MOVE_LEFT) ? olmsr_pkg::OP_MOVE_RIGHT
                                                 : olmsr_pkg::OP_MOVE_LEFT;
    end

    dec_skip = ((dec_op == olmsr_pkg::OP_MOVE_LEFT)  && (dx == pyv)) ||
               ((dec_op == olmsr_pkg::OP_MOVE_RIGHT) && (dx == nyv));

    // Join pairs (a, b): next[a] = b, prev[b] = a, applied in order
    dec_a[3] = '0;
    dec_b[3] = '0;
    if (dec_op == olmsr_pkg::OP_MOVE_LEFT) begin
      dec_a[0] = pxv; dec_b[0] = nxv;
      dec_a[1] = pyv; dec_b[1] = dx;
      dec_a[2] = dx;  dec_b[2] = dy;
      dec_left = 2'd2;
    end else if (dec_op == olmsr_pkg::OP_MOVE_RIGHT) begin
      dec_a[0] = pxv; dec_b[0] = nxv;
      dec_a[1] = dy;  dec_b[1] = dx;
      dec_a[2] = dx;  dec_b[2] = nyv;
      dec_left = 2'd2;
    end else if (nxv == dy) begin
      // Swap of neighbors
      dec_a[0] = pxv; dec_b[0] = dy;
      dec_a[1] = dx;  dec_b[1] = nyv;
      dec_a[2] = dy;  dec_b[2] = dx;
      dec_left = 2'd2;
    end else begin
      dec_a[0] = pxv; dec_b[0] = dy;
      dec_a[1] = dy;  dec_b[1] = nxv;
      dec_a[2] = pyv; dec_b[2] = dx;
      dec_a[3] = dx;  dec_b[3] = nyv;
      dec_left = 2'd3;
    end
  end

  // Next state, table accesses and datapath updates
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    nx_nxt        = nx_r;
    px_nxt        = px_r;
    ja_nxt        = ja_r;
    jb_nxt        = jb_r;
    jleft_nxt     = jleft_r;
    i_nxt         = i_r;
    sum_nxt       = sum_r;
    odd_nxt       = odd_r;
    steps_nxt     = steps_r;
    rev_nxt       = rev_r;
    out_sum_nxt   = out_sum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    n_we          = 1'b0;
    p_we          = 1'b0;
    n_waddr       = '0;
    n_wdata       = '0;
    p_waddr       = '0;
    p_wdata       = '0;
    raddr         = '0;

    case (state_r)
      olmsr_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            olmsr_pkg::OP_INIT: begin
              // Head sentinel first, then sweep the boxes
              n_we      = 1'b1;
              n_waddr   = '0;
              n_wdata   = IDX_W'(1);
              p_we      = 1'b1;
              p_waddr   = '0;
              p_wdata   = count;
              rev_nxt   = 1'b0;
              i_nxt     = IDX_W'(1);
              state_nxt = olmsr_pkg::S_INIT;
            end
            olmsr_pkg::OP_MOVE_LEFT, olmsr_pkg::OP_MOVE_RIGHT, olmsr_pkg::OP_SWAP: begin
              op_nxt = in_operation;
              x_nxt  = x_in;
              y_nxt  = y_in;
              raddr  = x_in;
              if (args_ok) begin
                state_nxt = olmsr_pkg::S_RD_Y;
              end
            end
            olmsr_pkg::OP_REVERSE: begin
              rev_nxt = !rev_r;
            end
            olmsr_pkg::OP_REPORT: begin
              raddr     = '0;
              sum_nxt   = '0;
              odd_nxt   = 1'b1;
              steps_nxt = '0;
              state_nxt = olmsr_pkg::S_WALK;
            end
            default: begin
            end
          endcase
        end
      end

      olmsr_pkg::S_INIT: begin
        // Link box i to its natural neighbors
        n_we    = 1'b1;
        n_waddr = i_r;
        n_wdata = (i_r == count) ? '0 : i_r + IDX_W'(1);
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = i_r - IDX_W'(1);
        if (i_r == count) begin
          state_nxt = olmsr_pkg::S_IDLE;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end

      olmsr_pkg::S_RD_Y: begin
        // Links of x arrive; fetch links of y
        raddr     = y_r;
        nx_nxt    = n_fx;
        px_nxt    = p_fx;
        state_nxt = olmsr_pkg::S_DECIDE;
      end

      olmsr_pkg::S_DECIDE: begin
        if (dec_skip) begin
          state_nxt = olmsr_pkg::S_IDLE;
        end else begin
          ja_nxt    = dec_a;
          jb_nxt    = dec_b;
          jleft_nxt = dec_left;
          state_nxt = olmsr_pkg::S_JOIN;
        end
      end

      olmsr_pkg::S_JOIN: begin
        // Apply one join per cycle, then shift the queue
        n_we      = 1'b1;
        n_waddr   = ja_r[0];
        n_wdata   = jb_r[0];
        p_we      = 1'b1;
        p_waddr   = jb_r[0];
        p_wdata   = ja_r[0];
        ja_nxt[0] = ja_r[1];
        ja_nxt[1] = ja_r[2];
        ja_nxt[2] = ja_r[3];
        jb_nxt[0] = jb_r[1];
        jb_nxt[1] = jb_r[2];
        jb_nxt[2] = jb_r[3];
        if (jleft_r == 2'd0) begin
          state_nxt = olmsr_pkg::S_IDLE;
        end else begin
          jleft_nxt = jleft_r - 2'd1;
        end
      end

      olmsr_pkg::S_WALK: begin
        // Follow next links from the head, adding every other label
        if (n_fx != '0 && steps_r <= STEP_W'(MAX_BOXES)) begin
          if (odd_r) begin
            sum_nxt = sum_r + SUM_W'(n_fx);
          end
          raddr     = n_fx;
          odd_nxt   = !odd_r;
          steps_nxt = steps_r + STEP_W'(1);
        end else begin
          state_nxt = olmsr_pkg::S_FIX;
        end
      end

      olmsr_pkg::S_FIX: begin
        // Reversed with an even count: odd positions become the even ones
        if (rev_r && !count[0]) begin
          sum_nxt = tri_sum - sum_r;
        end
        state_nxt = olmsr_pkg::S_OUT;
      end

      olmsr_pkg::S_OUT: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = sum_r;
          state_nxt     = olmsr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = olmsr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olmsr_pkg::S_IDLE;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    nx_r      <= nx_nxt;
    px_r      <= px_nxt;
    ja_r      <= ja_nxt;
    jb_r      <= jb_nxt;
    jleft_r   <= jleft_nxt;
    i_r       <= i_nxt;
    sum_r     <= sum_nxt;
    odd_r     <= odd_nxt;
    steps_r   <= steps_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign in_ready             = (state_r == olmsr_pkg::S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_odd_position_sum = out_sum_r;

  // Link writes stay inside the table
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_we || p_we) |-> (32'(n_waddr) <= 32'(MAX_BOXES) && 32'(p_waddr) <= 32'(MAX_BOXES)))
    else $error("link write outside table");

  // Init sweep index stays within 1..count
  a_init_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olmsr_pkg::S_INIT) |-> (i_r != '0 && 32'(i_r) <= 32'(count)))
    else $error("init index out of range");

  // Pointer walk is bounded
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olmsr_pkg::S_WALK) |-> (32'(steps_r) <= 32'(MAX_BOXES) + 32'd1))
    else $error("walk step count overrun");

  // A result appears only out of the output state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == olmsr_pkg::S_OUT))
    else $error("result raised outside output state");

  // An accepted reverse flips the flag
  a_reverse_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == olmsr_pkg::OP_REVERSE) |=>
    (rev_r != $past(rev_r)))
    else $error("reverse did not toggle");

endmodule
